@@ sv/hkb_pkg.sv @@
// ----------------------------------------------------------------------------
// Hashed key builder package
// Shared constants, payload types, character helpers and the FNV-1a hash step.
// ----------------------------------------------------------------------------
package hkb_pkg;

	localparam int PREFIX_LEN  = 8;
	localparam int KEY_MAX     = 26;
	localparam int QUEUE_DEPTH = 2;

	localparam int CNT_W = $clog2(PREFIX_LEN + 1);
	localparam int IDX_W = (PREFIX_LEN > 1) ? $clog2(PREFIX_LEN) : 1;
	localparam int HEX_DIGITS = 16;
	localparam int HEX_W = $clog2(HEX_DIGITS + 1);

	localparam logic [63:0] HASH_BASIS = 64'hcbf29ce484222325;
	localparam logic [7:0]  CAP_RESET  = 8'd255;
	localparam logic [7:0]  CHAR_DASH  = 8'h2d;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       in_last;
	} in_item_t;

	typedef struct packed {
		logic [7:0] key_char;
		logic       refused;
		logic       key_last;
	} out_item_t;

	typedef logic [PREFIX_LEN-1:0][7:0] prefix_t;

	typedef struct packed {
		logic [63:0]      hash;
		prefix_t          prefix;
		logic [CNT_W-1:0] count;
		logic             refused;
	} job_t;

	function automatic logic is_alnum(input logic [7:0] b);
		return b inside {[8'h30:8'h39], [8'h41:8'h5a], [8'h61:8'h7a]};
	endfunction

	function automatic logic [7:0] hex_char(input logic [3:0] nib);
		if (nib < 4'd10) begin
			return 8'h30 + {4'd0, nib};
		end else begin
			return 8'h57 + {4'd0, nib};
		end
	endfunction

	// The prime is 2^40 + 2^8 + 0xb3, so the product is a sum of shifted copies.
	function automatic logic [63:0] fnv_step(input logic [63:0] h, input logic [7:0] b);
		logic [63:0] x;
		x = h ^ {56'd0, b};
		return (x << 40) + (x << 8) + (x << 7) + (x << 5) + (x << 4) + (x << 1) + x;
	endfunction

endpackage

@@ sv/hkb_front.sv @@
// ----------------------------------------------------------------------------
// Hashed key builder front end
// Accepts identifier bytes, folds them into the hash, keeps the prefix and
// queues one job per identifier.
// ----------------------------------------------------------------------------
module hkb_front import hkb_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        item_valid,
	output logic        item_stall,
	input  in_item_t    item,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	output logic        push,
	output job_t        push_data,
	input  logic        queue_full
);

	logic [63:0]      hash_q;
	prefix_t          prefix_q;
	logic [CNT_W-1:0] count_q;
	logic [7:0]       cap_q;

	logic             accept;
	logic             keep;
	logic [63:0]      hash_n;
	prefix_t          prefix_n;
	logic [CNT_W-1:0] count_n;

	assign item_stall = queue_full;
	assign accept     = item_valid && !item_stall;

	always_comb begin
		hash_n   = fnv_step(hash_q, item.in_byte);
		keep     = is_alnum(item.in_byte) && (count_q < CNT_W'(PREFIX_LEN));
		prefix_n = prefix_q;
		count_n  = count_q;
		if (keep) begin
			prefix_n[count_q[IDX_W-1:0]] = item.in_byte;
			count_n = count_q + 1'b1;
		end
	end

	assign push              = accept && item.in_last;
	assign push_data.hash    = hash_n;
	assign push_data.prefix  = prefix_n;
	assign push_data.count   = count_n;
	assign push_data.refused = cap_q < 8'(KEY_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hash_q  <= HASH_BASIS;
			count_q <= '0;
			cap_q   <= CAP_RESET;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (accept) begin
				if (item.in_last) begin
					hash_q  <= HASH_BASIS;
					count_q <= '0;
				end else begin
					hash_q  <= hash_n;
					count_q <= count_n;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			prefix_q <= prefix_n;
		end
	end

endmodule

@@ sv/hkb_queue.sv @@
// ----------------------------------------------------------------------------
// Hashed key builder job queue
// A short first-in first-out queue of finished identifiers between the
// front end and the key emitter.
// ----------------------------------------------------------------------------
module hkb_queue import hkb_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  job_t push_data,
	output logic full,
	input  logic pop,
	output job_t pop_data,
	output logic empty
);

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

	job_t              slots_q [QUEUE_DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [FILL_W-1:0] fill_q;

	assign full     = fill_q == FILL_W'(QUEUE_DEPTH);
	assign empty    = fill_q == '0;
	assign pop_data = slots_q[rd_ptr_q];

	function automatic logic [PTR_W-1:0] wrap_inc(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(QUEUE_DEPTH - 1)) begin
			return '0;
		end else begin
			return p + 1'b1;
		end
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wrap_inc(wr_ptr_q);
			end
			if (pop) begin
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			end
			if (push && !pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (pop && !push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

@@ sv/hkb_back.sv @@
// ----------------------------------------------------------------------------
// Hashed key builder key emitter
// Takes one job at a time from the queue and sends its key one character
// per beat through an output register.
// ----------------------------------------------------------------------------
module hkb_back import hkb_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      queue_empty,
	output logic      pop,
	input  job_t      pop_data,
	output logic      key_valid,
	input  logic      key_stall,
	output out_item_t key
);

	logic             busy_q;
	logic             refused_q;
	logic             dash_q;
	logic [CNT_W-1:0] pfx_left_q;
	logic [HEX_W-1:0] hex_left_q;
	prefix_t          prefix_q;
	logic [63:0]      hash_q;
	logic             key_valid_q;
	out_item_t        key_q;

	logic             advance;
	out_item_t        beat;
	logic             done;

	assign advance   = !key_valid_q || !key_stall;
	assign pop       = !busy_q && !queue_empty;
	assign key_valid = key_valid_q;
	assign key       = key_q;

	always_comb begin
		beat = '0;
		done = 1'b0;
		if (refused_q) begin
			beat.refused  = 1'b1;
			beat.key_last = 1'b1;
			done          = 1'b1;
		end else if (pfx_left_q != '0) begin
			beat.key_char = prefix_q[0];
		end else if (dash_q) begin
			beat.key_char = CHAR_DASH;
		end else begin
			beat.key_char = hex_char(hash_q[63:60]);
			beat.key_last = hex_left_q == HEX_W'(1);
			done          = beat.key_last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			key_valid_q <= 1'b0;
		end else begin
			if (pop) begin
				busy_q <= 1'b1;
			end else if (busy_q && advance && done) begin
				busy_q <= 1'b0;
			end
			if (advance) begin
				key_valid_q <= busy_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			refused_q  <= pop_data.refused;
			pfx_left_q <= pop_data.count;
			dash_q     <= pop_data.count != '0;
			hex_left_q <= HEX_W'(HEX_DIGITS);
			prefix_q   <= pop_data.prefix;
			hash_q     <= pop_data.hash;
		end else if (busy_q && advance) begin
			if (pfx_left_q != '0) begin
				pfx_left_q <= pfx_left_q - 1'b1;
				prefix_q   <= prefix_q >> 8;
			end else if (dash_q) begin
				dash_q <= 1'b0;
			end else begin
				hex_left_q <= hex_left_q - 1'b1;
				hash_q     <= hash_q << 4;
			end
		end
		if (advance) begin
			key_q <= beat;
		end
	end

endmodule

@@ sv/hashed_key_builder.sv @@
// ----------------------------------------------------------------------------
// Hashed key builder
// Builds a readable prefix plus 64-bit FNV-1a hex key from identifier bytes.
// Throughput: one input byte per cycle while the job queue is not full;
// keys leave at one character per cycle while key_stall is low, and the
// output idles between keys while the emitter loads the next job.
// Input stalls only while the two-entry job queue is full.
// Reset: hash to the offset basis, prefix empty, capacity 255, queue empty.
// ----------------------------------------------------------------------------
module hashed_key_builder import hkb_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       item_valid,
	output logic       item_stall,
	input  in_item_t   item,
	output logic       key_valid,
	input  logic       key_stall,
	output out_item_t  key,
	input  logic       cfg_we,
	input  logic [7:0] cfg_wdata
);

	logic push;
	job_t push_data;
	logic queue_full;
	logic pop;
	job_t pop_data;
	logic queue_empty;

	hkb_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.item       (item),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.push       (push),
		.push_data  (push_data),
		.queue_full (queue_full)
	);

	hkb_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (queue_full),
		.pop       (pop),
		.pop_data  (pop_data),
		.empty     (queue_empty)
	);

	hkb_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (queue_empty),
		.pop         (pop),
		.pop_data    (pop_data),
		.key_valid   (key_valid),
		.key_stall   (key_stall),
		.key         (key)
	);

endmodule

@@ verif/tb_hashed_key_builder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Hashed key builder testbench
// Streams identifier bytes into the block, directed first and then random,
// under several capacity settings with random input gaps and output stalls.
// A scoreboard computes the prefix-plus-FNV-1a key (or the refused beat) for
// every identifier and compares each key beat in order, field by field.
// ----------------------------------------------------------------------------
module tb_hashed_key_builder import hkb_pkg::*;;

	localparam logic [63:0] FNV_PRIME = 64'd1099511628211;
	localparam int PHASE_BYTES = 30;
	localparam int PHASES = 8;

	class key_predictor;
		logic [63:0] hash;
		logic [7:0]  prefix [PREFIX_LEN];
		int          count;
		logic [7:0]  capacity;
		out_item_t   expected_keys [$];
		int          errors;

		function new();
			clear_identifier();
			capacity = CAP_RESET;
			errors = 0;
		endfunction

		function void clear_identifier();
			hash = HASH_BASIS;
			count = 0;
		endfunction

		function void set_capacity(input logic [7:0] value);
			capacity = value;
		endfunction

		function logic [7:0] hex_digit(input logic [3:0] nib);
			return (nib < 4'd10) ? 8'h30 + 8'(nib) : 8'h61 + 8'(nib) - 8'd10;
		endfunction

		function void push(input logic [7:0] ch, input logic refused, input logic last);
			out_item_t beat;
			beat.key_char = ch;
			beat.refused = refused;
			beat.key_last = last;
			expected_keys.push_back(beat);
		endfunction

		function void note_byte(input in_item_t beat);
			logic [7:0] b;
			logic alnum;
			b = beat.in_byte;
			hash = (hash ^ {56'd0, b}) * FNV_PRIME;
			alnum = (b >= "0" && b <= "9") || (b >= "A" && b <= "Z") || (b >= "a" && b <= "z");
			if (alnum && count < PREFIX_LEN) begin
				prefix[count] = b;
				count++;
			end
			if (!beat.in_last) begin
				return;
			end
			if (int'(capacity) < KEY_MAX) begin
				push(8'h00, 1'b1, 1'b1);
			end else begin
				for (int i = 0; i < count; i++) begin
					push(prefix[i], 1'b0, 1'b0);
				end
				if (count > 0) begin
					push(CHAR_DASH, 1'b0, 1'b0);
				end
				for (int d = HEX_DIGITS - 1; d >= 0; d--) begin
					push(hex_digit(hash[d*4 +: 4]), 1'b0, d == 0);
				end
			end
			clear_identifier();
		endfunction

		function void check_key(input out_item_t got);
			out_item_t want;
			if (expected_keys.size() == 0) begin
				errors++;
				$error("unexpected key beat: key_char %h refused %b key_last %b",
					got.key_char, got.refused, got.key_last);
				return;
			end
			want = expected_keys.pop_front();
			if (got.key_char !== want.key_char) begin
				errors++;
				$error("key_char: expected %h, actual %h", want.key_char, got.key_char);
			end
			if (got.refused !== want.refused) begin
				errors++;
				$error("refused: expected %b, actual %b", want.refused, got.refused);
			end
			if (got.key_last !== want.key_last) begin
				errors++;
				$error("key_last: expected %b, actual %b", want.key_last, got.key_last);
			end
		endfunction

		function int pending();
			return expected_keys.size();
		endfunction
	endclass

	logic       clk;
	logic       arst_n;
	logic       item_valid;
	logic       item_stall;
	in_item_t   item;
	logic       key_valid;
	logic       key_stall;
	out_item_t  key;
	logic       cfg_we;
	logic [7:0] cfg_wdata;

	key_predictor model;
	bit steady;

	hashed_key_builder u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_valid(item_valid),
		.item_stall(item_stall),
		.item      (item),
		.key_valid (key_valid),
		.key_stall (key_stall),
		.key       (key),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55) begin
			return 0;
		end else if (r < 85) begin
			return $urandom_range(1, 3);
		end else if (r < 97) begin
			return $urandom_range(4, 10);
		end
		return $urandom_range(20, 60);
	endfunction

	task automatic send_byte(input logic [7:0] b, input logic last);
		in_item_t beat;
		int gap;
		beat.in_byte = b;
		beat.in_last = last;
		gap = steady ? 0 : pick_gap();
		if (gap > 0) begin
			@(negedge clk);
			item_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		item_valid <= 1'b1;
		item <= beat;
		do @(posedge clk); while (item_stall);
		model.note_byte(beat);
	endtask

	task automatic send_text(input string s, input logic close);
		for (int i = 0; i < s.len(); i++) begin
			send_byte(s[i], close && i == s.len() - 1);
		end
	endtask

	task automatic send_random_ident(output int sent);
		int len;
		int pick;
		int r;
		logic [7:0] b;
		pick = $urandom_range(0, 99);
		if (pick < 70) begin
			len = $urandom_range(1, 10);
		end else if (pick < 95) begin
			len = $urandom_range(11, 24);
		end else begin
			len = $urandom_range(25, 40);
		end
		for (int i = 0; i < len; i++) begin
			if ($urandom_range(0, 9) < 6) begin
				r = $urandom_range(0, 61);
				if (r < 10) begin
					b = 8'h30 + 8'(r);
				end else if (r < 36) begin
					b = 8'h41 + 8'(r - 10);
				end else begin
					b = 8'h61 + 8'(r - 36);
				end
			end else begin
				b = 8'($urandom_range(1, 255));
			end
			send_byte(b, i == len - 1);
		end
		sent = len;
	endtask

	task automatic write_capacity(input logic [7:0] value);
		@(negedge clk);
		item_valid <= 1'b0;
		while (model.pending() != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		model.set_capacity(value);
	endtask

	always @(posedge clk) begin
		if (arst_n && key_valid && !key_stall) begin
			model.check_key(key);
		end
	end

	initial begin
		int run;
		key_stall = 1'b0;
		@(posedge arst_n);
		forever begin
			if ($urandom_range(0, 9) == 0) begin
				run = $urandom_range(30, 100);
			end else begin
				run = $urandom_range(0, 6);
			end
			repeat (run) begin
				@(negedge clk);
				key_stall <= 1'b0;
			end
			run = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 3);
			repeat (run) begin
				@(negedge clk);
				key_stall <= 1'b1;
			end
		end
	end

	initial begin
		#60_000_000;
		$display("Mismatches found");
		$finish;
	end

	initial begin
		int sent;
		int phase_bytes;
		int waited;
		logic [7:0] cap;
		model = new();
		steady = 1'b0;
		arst_n = 1'b0;
		item_valid = 1'b0;
		item = '0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;

		send_byte(8'hff, 1'b1);
		send_byte(8'h01, 1'b1);
		send_text("09AZaz", 1'b0);
		send_byte(8'h00, 1'b0);
		send_text("/:@[`{", 1'b1);
		send_text("abcdefghij", 1'b1);

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: cap = 8'(KEY_MAX);
				1: cap = 8'(KEY_MAX - 1);
				2: cap = 8'd0;
				3: cap = 8'd255;
				default: cap = 8'($urandom_range(0, 255));
			endcase
			write_capacity(cap);
			steady = ($urandom_range(0, 3) == 0);
			phase_bytes = 0;
			while (phase_bytes < PHASE_BYTES) begin
				send_random_ident(sent);
				phase_bytes += sent;
			end
		end

		@(negedge clk);
		item_valid <= 1'b0;
		waited = 0;
		while (model.pending() != 0 && waited < 200000) begin
			@(negedge clk);
			waited++;
		end
		repeat (10) @(negedge clk);
		if (model.pending() != 0) begin
			model.errors++;
			$error("%0d expected key beats never arrived", model.pending());
		end
		if (model.errors == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

@@ sim.f @@
sv/hkb_pkg.sv
sv/hkb_front.sv
sv/hkb_queue.sv
sv/hkb_back.sv
sv/hashed_key_builder.sv
verif/tb_hashed_key_builder.sv
